// File: rtl/core/box_support_normal_classifier_macros.svh
// ----------------------------------------------------------------------------
// Box support normal classifier assertion macros
// Shared concurrent assertion helpers for the classifier checker.
// ----------------------------------------------------------------------------
`ifndef BOX_SUPPORT_NORMAL_CLASSIFIER_MACROS_SVH
`define BOX_SUPPORT_NORMAL_CLASSIFIER_MACROS_SVH

// Plain property, sampled on the rising clock edge and disabled in reset.
`define BSNC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A stalled transfer keeps valid high and holds its payload.
`define BSNC_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, pay, msg) \
  `BSNC_ASSERT(lbl, clk, rstn, (vld) && !(rdy) |=> (vld) && $stable(pay), msg)

`endif

// File: rtl/core/bsnc_pkg.sv
// ----------------------------------------------------------------------------
// Box support normal classifier package
// Widths, payload types, the lattice direction table and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bsnc_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int SIZE_WIDTH      = 16;
  localparam int IN_TDATA_WIDTH  = ((3 * COMPONENT_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = 8;

  // Scaled component, sum over up to three axes, and its magnitude.
  localparam int PROD_WIDTH  = COMPONENT_WIDTH + SIZE_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 2;
  localparam int MAG_WIDTH   = PROD_WIDTH + 1;
  localparam int K_WIDTH     = 16;
  localparam int SCORE_WIDTH = MAG_WIDTH + K_WIDTH;

  localparam int NUM_AXES       = 13;
  localparam int AXIS_IDX_WIDTH = $clog2(NUM_AXES);

  localparam int NUM_REGS       = 3;
  localparam int CFG_ADDR_WIDTH = $clog2(NUM_REGS) + 2;
  localparam int CFG_DATA_WIDTH = 32;

  localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = SIZE_WIDTH'(256);

  // Inverse lengths in unsigned Q1.15.
  localparam logic [K_WIDTH-1:0] K_FACE   = K_WIDTH'(32768);
  localparam logic [K_WIDTH-1:0] K_EDGE   = K_WIDTH'(23170);
  localparam logic [K_WIDTH-1:0] K_CORNER = K_WIDTH'(18919);

  typedef enum logic [1:0] {
    REG_BOX_SIZE_X,
    REG_BOX_SIZE_Y,
    REG_BOX_SIZE_Z
  } cfg_reg_e;

  typedef logic signed [1:0] comp_t;

  localparam comp_t C_POS  = 2'sb01;
  localparam comp_t C_ZERO = 2'sb00;
  localparam comp_t C_NEG  = 2'sb11;

  typedef struct packed {
    comp_t z;
    comp_t y;
    comp_t x;
  } lattice_t;

  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  typedef struct packed {
    prod_t pz;
    prod_t py;
    prod_t px;
  } scaled_t;

  typedef struct packed {
    logic                 neg;
    logic [MAG_WIDTH-1:0] mag;
  } sum_t;

  typedef struct packed {
    logic                   neg;
    logic [SCORE_WIDTH-1:0] score;
  } score_t;

  typedef struct packed {
    logic [SCORE_WIDTH-1:0]    score;
    logic [AXIS_IDX_WIDTH-1:0] idx;
    logic                      neg;
  } cand_t;

  typedef struct packed {
    logic     no_direction;
    lattice_t normal;
  } result_t;

  // Positive member of each candidate pair, in test order.
  function automatic lattice_t axis_vec(input logic [AXIS_IDX_WIDTH-1:0] idx);
    lattice_t v;
    unique case (idx)
      AXIS_IDX_WIDTH'(0):  v = '{z: C_ZERO, y: C_ZERO, x: C_POS};
      AXIS_IDX_WIDTH'(1):  v = '{z: C_ZERO, y: C_POS,  x: C_ZERO};
      AXIS_IDX_WIDTH'(2):  v = '{z: C_POS,  y: C_ZERO, x: C_ZERO};
      AXIS_IDX_WIDTH'(3):  v = '{z: C_ZERO, y: C_POS,  x: C_POS};
      AXIS_IDX_WIDTH'(4):  v = '{z: C_ZERO, y: C_NEG,  x: C_POS};
      AXIS_IDX_WIDTH'(5):  v = '{z: C_POS,  y: C_ZERO, x: C_POS};
      AXIS_IDX_WIDTH'(6):  v = '{z: C_NEG,  y: C_ZERO, x: C_POS};
      AXIS_IDX_WIDTH'(7):  v = '{z: C_POS,  y: C_POS,  x: C_ZERO};
      AXIS_IDX_WIDTH'(8):  v = '{z: C_NEG,  y: C_POS,  x: C_ZERO};
      AXIS_IDX_WIDTH'(9):  v = '{z: C_POS,  y: C_POS,  x: C_POS};
      AXIS_IDX_WIDTH'(10): v = '{z: C_POS,  y: C_NEG,  x: C_POS};
      AXIS_IDX_WIDTH'(11): v = '{z: C_NEG,  y: C_POS,  x: C_POS};
      AXIS_IDX_WIDTH'(12): v = '{z: C_NEG,  y: C_NEG,  x: C_POS};
      default:             v = '{z: C_ZERO, y: C_ZERO, x: C_ZERO};
    endcase
    return v;
  endfunction

  function automatic logic [K_WIDTH-1:0] axis_k(input lattice_t v);
    logic [1:0] nz;
    nz = {1'b0, v.x != C_ZERO} + {1'b0, v.y != C_ZERO} + {1'b0, v.z != C_ZERO};
    unique case (nz)
      2'd1:    return K_FACE;
      2'd2:    return K_EDGE;
      default: return K_CORNER;
    endcase
  endfunction

  // The earlier candidate keeps the lead on a tie.
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.score > a.score) ? b : a;
  endfunction

  function automatic lattice_t flip(input lattice_t v, input logic neg);
    lattice_t r;
    r.x = neg ? -v.x : v.x;
    r.y = neg ? -v.y : v.y;
    r.z = neg ? -v.z : v.z;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/box_support_normal_classifier.sv
// ----------------------------------------------------------------------------
// Box support normal classifier
// Scales a query direction by the box extents and returns the closest of the
// 26 face, edge and corner lattice directions.
//
//   Channel   Role         Contents
//   s_axis    input items  tdata: dir_x, dir_y, dir_z (signed Q1.15)
//   m_axis    results      tdata: normal_x, normal_y, normal_z; tuser: no_direction
//   APB       config       box_size_x/y/z at 0x0/0x4/0x8 (unsigned Q8.8)
//
// One direction enters per cycle unless back-pressure has filled every stage;
// each result passes through the scale, sum, weight, tree and result registers.
// Reset sets every box extent to 1.0 and empties the pipeline.
// Stages hold their contents under back-pressure and empty stages fill, so
// input is taken while a result waits as long as a stage is free.
// ----------------------------------------------------------------------------
`default_nettype none

module box_support_normal_classifier import bsnc_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // dir_x [15:0], dir_y [31:16], dir_z [47:32]
  input  wire logic                       s_axis_tvalid,
  output      logic                       s_axis_tready,
  input  wire logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
  // normal_x [1:0], normal_y [3:2], normal_z [5:4], zero [7:6]
  output      logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output      logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  // no_direction [0]
  output      logic [0:0]                 m_axis_tuser,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [CFG_ADDR_WIDTH-1:0]  paddr,
  input  wire logic [CFG_DATA_WIDTH-1:0]  pwdata,
  output      logic [CFG_DATA_WIDTH-1:0]  prdata,
  output      logic                       pready
);

  logic [SIZE_WIDTH-1:0] size_x_q, size_y_q, size_z_q;
  cfg_reg_e              reg_sel;
  logic                  cfg_write;

  logic                  scale_valid, scale_ready;
  scaled_t               scale_data;
  logic                  score_valid, score_ready;
  score_t [NUM_AXES-1:0] score_data;
  result_t               result;

  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_e'(paddr[CFG_ADDR_WIDTH-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
      size_z_q <= SIZE_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_BOX_SIZE_X: size_x_q <= pwdata[SIZE_WIDTH-1:0];
        REG_BOX_SIZE_Y: size_y_q <= pwdata[SIZE_WIDTH-1:0];
        REG_BOX_SIZE_Z: size_z_q <= pwdata[SIZE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BOX_SIZE_X: prdata = CFG_DATA_WIDTH'(size_x_q);
      REG_BOX_SIZE_Y: prdata = CFG_DATA_WIDTH'(size_y_q);
      REG_BOX_SIZE_Z: prdata = CFG_DATA_WIDTH'(size_z_q);
      default:        prdata = '0;
    endcase
  end

  bsnc_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .dir_x_i     (s_axis_tdata[COMPONENT_WIDTH-1:0]),
    .dir_y_i     (s_axis_tdata[2*COMPONENT_WIDTH-1:COMPONENT_WIDTH]),
    .dir_z_i     (s_axis_tdata[3*COMPONENT_WIDTH-1:2*COMPONENT_WIDTH]),
    .size_x_i    (size_x_q),
    .size_y_i    (size_y_q),
    .size_z_i    (size_z_q),
    .out_valid_o (scale_valid),
    .out_ready_i (scale_ready),
    .out_data_o  (scale_data)
  );

  bsnc_score u_score (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scale_valid),
    .in_ready_o  (scale_ready),
    .in_data_i   (scale_data),
    .out_valid_o (score_valid),
    .out_ready_i (score_ready),
    .out_score_o (score_data)
  );

  bsnc_select u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (score_valid),
    .in_ready_o  (score_ready),
    .in_score_i  (score_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (result)
  );

  assign m_axis_tdata = OUT_TDATA_WIDTH'({result.normal.z, result.normal.y,
                                          result.normal.x});
  assign m_axis_tuser = result.no_direction;

endmodule

`default_nettype wire

// File: rtl/core/bsnc_scale.sv
// ----------------------------------------------------------------------------
// Box support normal classifier, scaling stage
// Multiplies each query component by the box extent along its axis.
// ----------------------------------------------------------------------------
`default_nettype none

module bsnc_scale import bsnc_pkg::*; (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic signed [COMPONENT_WIDTH-1:0] dir_x_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] dir_y_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] dir_z_i,
  input  wire logic        [SIZE_WIDTH-1:0]      size_x_i,
  input  wire logic        [SIZE_WIDTH-1:0]      size_y_i,
  input  wire logic        [SIZE_WIDTH-1:0]      size_z_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      scaled_t                           out_data_o
);

  logic    valid_q;
  scaled_t data_q, data_d;

  // The product of a signed component and an unsigned extent fits in PROD_WIDTH.
  function automatic prod_t scale(input logic signed [COMPONENT_WIDTH-1:0] d,
                                  input logic [SIZE_WIDTH-1:0] s);
    logic signed [PROD_WIDTH:0] full;
    full = (PROD_WIDTH+1)'(d) * $signed({1'b0, s});
    return full[PROD_WIDTH-1:0];
  endfunction

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    data_d.px = scale(dir_x_i, size_x_i);
    data_d.py = scale(dir_y_i, size_y_i);
    data_d.pz = scale(dir_z_i, size_z_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/core/bsnc_score.sv
// ----------------------------------------------------------------------------
// Box support normal classifier, scoring stages
// Forms the signed axis sums, then weights each magnitude by 1/|c|.
// ----------------------------------------------------------------------------
`default_nettype none

module bsnc_score import bsnc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire scaled_t                in_data_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      score_t [NUM_AXES-1:0]  out_score_o
);

  logic                  sum_valid_q, score_valid_q;
  logic                  sum_ready, score_ready;
  sum_t   [NUM_AXES-1:0] sum_q, sum_d;
  score_t [NUM_AXES-1:0] score_q, score_d;

  assign score_ready = !score_valid_q || out_ready_i;
  assign sum_ready   = !sum_valid_q || score_ready;
  assign in_ready_o  = sum_ready;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    lattice_t                    vec;
    logic signed [SUM_WIDTH-1:0] s;
    logic signed [SUM_WIDTH-1:0] s_abs;

    assign vec = axis_vec(AXIS_IDX_WIDTH'(a));

    always_comb begin
      s = '0;
      if (vec.x == C_POS) s = s + SUM_WIDTH'(in_data_i.px);
      else if (vec.x == C_NEG) s = s - SUM_WIDTH'(in_data_i.px);
      if (vec.y == C_POS) s = s + SUM_WIDTH'(in_data_i.py);
      else if (vec.y == C_NEG) s = s - SUM_WIDTH'(in_data_i.py);
      if (vec.z == C_POS) s = s + SUM_WIDTH'(in_data_i.pz);
      else if (vec.z == C_NEG) s = s - SUM_WIDTH'(in_data_i.pz);
      s_abs = s[SUM_WIDTH-1] ? -s : s;
      sum_d[a].neg = s[SUM_WIDTH-1];
      sum_d[a].mag = s_abs[MAG_WIDTH-1:0];
    end

    // Constant coefficient, so this folds into a few adders.
    always_comb begin
      score_d[a].neg   = sum_q[a].neg;
      score_d[a].score = SCORE_WIDTH'(sum_q[a].mag) * SCORE_WIDTH'(axis_k(vec));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q   <= 1'b0;
      score_valid_q <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid_q <= in_valid_i;
      end
      if (score_ready) begin
        score_valid_q <= sum_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready && in_valid_i) begin
      sum_q <= sum_d;
    end
    if (score_ready && sum_valid_q) begin
      score_q <= score_d;
    end
  end

  assign out_valid_o = score_valid_q;
  assign out_score_o = score_q;

endmodule

`default_nettype wire

// File: rtl/core/bsnc_select.sv
// ----------------------------------------------------------------------------
// Box support normal classifier, selection stages
// Registered comparison tree that keeps the first highest score, then the
// result register that drives the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bsnc_select import bsnc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire score_t [NUM_AXES-1:0] in_score_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      result_t               out_data_o
);

  localparam int L1_N = (NUM_AXES + 1) / 2;
  localparam int L2_N = (L1_N + 1) / 2;
  localparam int L3_N = (L2_N + 1) / 2;

  logic                tree_valid_q, res_valid_q;
  logic                tree_ready, res_ready;
  cand_t [NUM_AXES-1:0] cand;
  cand_t [L1_N-1:0]    lvl1;
  cand_t [L2_N-1:0]    lvl2_q, lvl2_d;
  cand_t [L3_N-1:0]    lvl3;
  cand_t               best;
  result_t             res_q, res_d;

  assign res_ready  = !res_valid_q || out_ready_i;
  assign tree_ready = !tree_valid_q || res_ready;
  assign in_ready_o = tree_ready;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      cand[i].score = in_score_i[i].score;
      cand[i].idx   = AXIS_IDX_WIDTH'(i);
      cand[i].neg   = in_score_i[i].neg;
    end
    for (int i = 0; i < L1_N; i++) begin
      lvl1[i] = (2*i + 1 < NUM_AXES) ? pick(cand[2*i], cand[2*i + 1]) : cand[2*i];
    end
    for (int i = 0; i < L2_N; i++) begin
      lvl2_d[i] = (2*i + 1 < L1_N) ? pick(lvl1[2*i], lvl1[2*i + 1]) : lvl1[2*i];
    end
  end

  always_comb begin
    for (int i = 0; i < L3_N; i++) begin
      lvl3[i] = (2*i + 1 < L2_N) ? pick(lvl2_q[2*i], lvl2_q[2*i + 1]) : lvl2_q[2*i];
    end
    best = pick(lvl3[0], lvl3[L3_N-1]);
    // A zero best score means every candidate scored zero.
    res_d.no_direction = ~|best.score;
    res_d.normal       = res_d.no_direction ? lattice_t'('0)
                                            : flip(axis_vec(best.idx), best.neg);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (tree_ready) begin
        tree_valid_q <= in_valid_i;
      end
      if (res_ready) begin
        res_valid_q <= tree_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tree_ready && in_valid_i) begin
      lvl2_q <= lvl2_d;
    end
    if (res_ready && tree_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

// File: rtl/core/bsnc_checker.sv
// ----------------------------------------------------------------------------
// Box support normal classifier port checker
// Watches the top-level ports for result encoding and back-pressure slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_support_normal_classifier_macros.svh"

module bsnc_checker import bsnc_pkg::*; (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tready,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  input wire logic [0:0]                 m_axis_tuser
);

  // A stalled result keeps its data and flag.
  `BSNC_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, {m_axis_tuser, m_axis_tdata}, "result changed while stalled")

  // The input side can only back up when every stage is full and the result is stalled.
  `BSNC_ASSERT(a_backpressure, clk_i, rst_ni, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output back-pressure")

  // With no winner the normal is the zero vector.
  `BSNC_ASSERT(a_none_is_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0, "no_direction with a nonzero normal")

  // A winner is a nonzero vector with components in -1, 0 and 1.
  `BSNC_ASSERT(a_winner_legal, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[5:0] != 6'd0 && m_axis_tdata[1:0] != 2'b10 && m_axis_tdata[3:2] != 2'b10 && m_axis_tdata[5:4] != 2'b10 && m_axis_tdata[7:6] == 2'b00, "illegal lattice normal")

endmodule

bind box_support_normal_classifier bsnc_checker u_bsnc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
